// ----- src/lsb_first_bit_packer_core_assert.svh -----
// Assertion macros for the bit packer RTL.
// Depends on a clock named clk and an active-high reset named rst in scope.
`ifndef LSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH
`define LSB_FIRST_BIT_PACKER_CORE_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define LSBBP_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("bit packer: invariant violated");

// A condition in one cycle that forces another in the next cycle.
`define LSBBP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("bit packer: sequence violated");

`endif

// ----- src/lsbbp_pkg.sv -----
// Shared types and constants for the LSB-first bit packer.
// No dependencies; used by every module of the block.
package lsbbp_pkg;

  // Widest bit field one request may append.
  localparam int MAX_FIELD_BITS = 64;
  localparam int DATA_W         = 64;
  localparam int COUNT_W        = 7;
  localparam int PEND_W         = 7;
  localparam int PEND_CNT_W     = 3;
  // Bytes one request may produce: a padded partial byte plus eight data bytes.
  localparam int MAX_RESULTS    = 9;
  localparam int RES_CNT_W      = 4;
  localparam int BUF_W          = 8 * MAX_RESULTS;
  localparam int MAX_BYTES      = 8;

  // Request kinds.
  localparam logic CMD_BITS  = 1'b0;
  localparam logic CMD_BYTES = 1'b1;

  // One registered input request.
  typedef struct packed {
    logic               cmd;
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } item_t;

  // Result of packing one request against the pending bits.
  typedef struct packed {
    logic [BUF_W-1:0]      bytes;
    logic [RES_CNT_W-1:0]  n;
    logic [PEND_W-1:0]     pend_bits;
    logic [PEND_CNT_W-1:0] pend_count;
  } pack_res_t;

  // Load request from the input stage into the output buffer.
  typedef struct packed {
    logic                 load;
    logic [BUF_W-1:0]     bytes;
    logic [RES_CNT_W-1:0] n;
  } drain_in_t;

endpackage

// ----- src/lsbbp_pack.sv -----
// Combinational packing of one request against the pending partial byte.
// Depends on lsbbp_pkg.
module lsbbp_pack (
  input  lsbbp_pkg::item_t                        item,
  input  logic [lsbbp_pkg::PEND_W-1:0]            pend_bits,
  input  logic [lsbbp_pkg::PEND_CNT_W-1:0]        pend_count,
  output lsbbp_pkg::pack_res_t                    res
);

  logic [lsbbp_pkg::COUNT_W-1:0]   bit_cnt;
  logic [lsbbp_pkg::DATA_W-1:0]    val_mask;
  logic [lsbbp_pkg::DATA_W-1:0]    val;
  logic [lsbbp_pkg::BUF_W-1:0]     stream;
  logic [lsbbp_pkg::COUNT_W-1:0]   avail;
  logic [lsbbp_pkg::RES_CNT_W-1:0] bit_n;
  logic [lsbbp_pkg::BUF_W-1:0]     rest;
  logic [lsbbp_pkg::RES_CNT_W-1:0] byte_cnt;
  logic                            has_part;

  // Bit append: saturate the width, mask the field and place it after the pending bits.
  always_comb begin
    bit_cnt = (item.count > lsbbp_pkg::COUNT_W'(lsbbp_pkg::MAX_FIELD_BITS)) ?
              lsbbp_pkg::COUNT_W'(lsbbp_pkg::MAX_FIELD_BITS) : item.count;
    val_mask = (bit_cnt >= lsbbp_pkg::COUNT_W'(lsbbp_pkg::DATA_W)) ? '1 :
               ((lsbbp_pkg::DATA_W'(1) << bit_cnt) - lsbbp_pkg::DATA_W'(1));
    val      = item.data & val_mask;
    stream   = ({{(lsbbp_pkg::BUF_W - lsbbp_pkg::DATA_W){1'b0}}, val} << pend_count)
             | {{(lsbbp_pkg::BUF_W - lsbbp_pkg::PEND_W){1'b0}}, pend_bits};
    avail    = bit_cnt + lsbbp_pkg::COUNT_W'(pend_count);
    bit_n    = lsbbp_pkg::RES_CNT_W'(avail >> 3);
    // Bits of the incomplete byte are zero above the new count by construction.
    rest     = stream >> {bit_n, 3'b000};
  end

  // Byte append: flush any partial byte, then the saturated number of data bytes.
  always_comb begin
    byte_cnt = (item.count > lsbbp_pkg::COUNT_W'(lsbbp_pkg::MAX_BYTES)) ?
               lsbbp_pkg::RES_CNT_W'(lsbbp_pkg::MAX_BYTES) :
               item.count[lsbbp_pkg::RES_CNT_W-1:0];
    has_part = (pend_count != '0);
  end

  // Select the outcome for the request kind.
  always_comb begin
    unique case (item.cmd)
      lsbbp_pkg::CMD_BITS: begin
        res.bytes      = stream;
        res.n          = bit_n;
        res.pend_bits  = rest[lsbbp_pkg::PEND_W-1:0];
        res.pend_count = avail[lsbbp_pkg::PEND_CNT_W-1:0];
      end
      default: begin
        res.bytes      = has_part ? {item.data, 1'b0, pend_bits} : {8'd0, item.data};
        res.n          = byte_cnt + lsbbp_pkg::RES_CNT_W'(has_part);
        res.pend_bits  = '0;
        res.pend_count = '0;
      end
    endcase
  end

endmodule

// ----- src/lsbbp_drain.sv -----
// Output buffer that hands out the bytes of one packed request, one per cycle while m_tready is high.
// Depends on lsbbp_pkg and the assertion macros.
`include "lsb_first_bit_packer_core_assert.svh"

module lsbbp_drain (
  input  logic                 clk,
  input  logic                 rst,
  input  lsbbp_pkg::drain_in_t din,
  output logic                 can_load,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,
  output logic                 m_tlast
);

  logic [lsbbp_pkg::BUF_W-1:0]     buf_bytes;
  logic [lsbbp_pkg::RES_CNT_W-1:0] remain;
  logic                            take;

  // The buffer can take new bytes when empty or when its final byte leaves now.
  assign take     = m_tvalid && m_tready;
  assign can_load = (remain == '0) || ((remain == lsbbp_pkg::RES_CNT_W'(1)) && m_tready);

  assign m_tvalid = (remain != '0);
  assign m_tdata  = buf_bytes[7:0];
  assign m_tlast  = (remain == lsbbp_pkg::RES_CNT_W'(1));

  // Byte count of the request being handed out.
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (din.load) begin
      remain <= din.n;
    end else if (take) begin
      remain <= remain - lsbbp_pkg::RES_CNT_W'(1);
    end
  end

  // Byte buffer, shifted down as each byte is taken.
  always_ff @(posedge clk) begin
    if (din.load) begin
      buf_bytes <= din.bytes;
    end else if (take) begin
      buf_bytes <= buf_bytes >> 8;
    end
  end

  `LSBBP_ASSERT_ALWAYS(a_remain_range, remain <= lsbbp_pkg::RES_CNT_W'(lsbbp_pkg::MAX_RESULTS))
  `LSBBP_ASSERT_ALWAYS(a_load_allowed, !din.load || can_load)
  `LSBBP_ASSERT_NEXT(a_load_shows, din.load && (din.n != '0), m_tvalid)
  `LSBBP_ASSERT_NEXT(a_last_empties, take && m_tlast && !din.load, !m_tvalid)

endmodule

// ----- src/lsb_first_bit_packer_core.sv -----
// LSB-first bit packer: appends bit fields or whole bytes to a byte stream.
// An accepted request passes through the input register and then the output buffer before its first byte can be taken.
// Throughput: one request per cycle while m_tready is high, when it yields at most one byte; otherwise
// the next request waits in the input register while the one-byte-wide output port hands out the bytes (up to nine).
// Reset (synchronous, active high) empties both stages and clears the pending bits.
module lsb_first_bit_packer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // data [63:0], count [70:64], zero [71]
  input  logic        s_tuser,   // cmd [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte [7:0]
  output logic        m_tlast
);

  lsbbp_pkg::item_t                        item;
  logic                                    item_valid;
  logic [lsbbp_pkg::PEND_W-1:0]            pend_bits;
  logic [lsbbp_pkg::PEND_CNT_W-1:0]        pend_count;
  lsbbp_pkg::pack_res_t                    res;
  lsbbp_pkg::drain_in_t                    din;
  logic                                    can_load;
  logic                                    commit;
  logic                                    s_take;

  // A request leaves the input register when it yields nothing or the buffer frees.
  assign commit   = item_valid && ((res.n == '0) || can_load);
  assign s_tready = !item_valid || commit;
  assign s_take   = s_tvalid && s_tready;

  assign din.load  = commit && (res.n != '0);
  assign din.bytes = res.bytes;
  assign din.n     = res.n;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_take) begin
      item.cmd   <= s_tuser;
      item.data  <= s_tdata[lsbbp_pkg::DATA_W-1:0];
      item.count <= s_tdata[lsbbp_pkg::DATA_W +: lsbbp_pkg::COUNT_W];
    end
  end

  // Pending partial byte, updated as each request commits.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_count <= '0;
    end else if (commit) begin
      pend_bits  <= res.pend_bits;
      pend_count <= res.pend_count;
    end
  end

  lsbbp_pack u_pack (
    .item       (item),
    .pend_bits  (pend_bits),
    .pend_count (pend_count),
    .res        (res)
  );

  lsbbp_drain u_drain (
    .clk      (clk),
    .rst      (rst),
    .din      (din),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- test/lsb_first_bit_packer_core_test.sv -----
// Self-checking testbench for lsb_first_bit_packer_core: bit and byte appends,
// checked byte by byte against a predictor. Depends on lsbbp_pkg and the core RTL.
module lsb_first_bit_packer_core_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  // One append request as the sender offers it, with its lead-in gap.
  typedef struct {
    logic                          cmd;
    logic [lsbbp_pkg::DATA_W-1:0]  data;
    logic [lsbbp_pkg::COUNT_W-1:0] count;
    int                            gap;
    bit                            hold;
  } append_req_t;

  // One stream byte that the core should produce.
  typedef struct {
    logic [7:0] value;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // data [63:0], count [70:64], zero [71]
  logic        s_tuser = 1'b0;  // cmd [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;  // out_byte [7:0]
  logic        m_tlast;

  append_req_t  append_queue[$];
  stream_byte_t stream_expect[$];

  // Predictor state: bits that do not yet form a whole byte.
  logic [lsbbp_pkg::PEND_W-1:0]     pend_bits = '0;
  logic [lsbbp_pkg::PEND_CNT_W-1:0] pend_cnt = '0;

  bit req_taken = 1'b0;
  bit byte_taken = 1'b0;
  int send_wait = 0;
  int rx_wait = 0;
  bit rx_calm = 1'b0;
  int rx_seen = 0;
  int cycles = 0;
  int errors = 0;
  int reqs_done = 0;
  int bytes_done = 0;
  int pad_bytes = 0;
  int clamped = 0;

  lsb_first_bit_packer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the bytes one accepted request produces and updates the pending bits.
  task automatic predict_bytes(input append_req_t r);
    logic [127:0]  acc;
    logic [63:0]   val;
    int            nbits;
    int            nbytes;
    int            avail;
    stream_byte_t  fresh[$];
    if (r.cmd == lsbbp_pkg::CMD_BITS) begin
      nbits = (r.count > lsbbp_pkg::MAX_FIELD_BITS) ? lsbbp_pkg::MAX_FIELD_BITS
                                                     : int'(r.count);
      if (r.count > lsbbp_pkg::MAX_FIELD_BITS) clamped++;
      val = (nbits == 64) ? r.data : (r.data & ((64'd1 << nbits) - 64'd1));
      acc = ({64'd0, val} << pend_cnt) | {121'd0, pend_bits};
      avail = int'(pend_cnt) + nbits;
      while (avail >= 8) begin
        fresh.push_back('{acc[7:0], 1'b0});
        acc = acc >> 8;
        avail -= 8;
      end
      pend_cnt = 3'(avail);
      pend_bits = acc[6:0];
    end else begin
      nbytes = (r.count > lsbbp_pkg::MAX_BYTES) ? lsbbp_pkg::MAX_BYTES : int'(r.count);
      if (r.count > lsbbp_pkg::MAX_BYTES) clamped++;
      // Alignment: a partial byte goes out first, zero-padded.
      if (pend_cnt != 0) begin
        fresh.push_back('{{1'b0, pend_bits}, 1'b0});
        pad_bytes++;
      end
      pend_bits = '0;
      pend_cnt = '0;
      for (int i = 0; i < nbytes; i++) fresh.push_back('{r.data[8*i +: 8], 1'b0});
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
    foreach (fresh[i]) stream_expect.push_back(fresh[i]);
  endtask

  task automatic add_req(input logic cmd, input logic [63:0] data,
                         input logic [6:0] count, input int gap, input bit hold);
    append_queue.push_back('{cmd, data, count, gap, hold});
  endtask

  // Monitor: checks accepted bytes, then predicts for an accepted request.
  always @(posedge clk) begin
    append_req_t r;
    stream_byte_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bytes still expected", $time, stream_expect.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      req_taken <= !rst && s_tvalid && s_tready;
      byte_taken <= !rst && m_tvalid && m_tready;
      if (!rst && m_tvalid && m_tready) begin
        bytes_done++;
        if (stream_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte: expected none, actual byte %h last %b",
                   $time, m_tdata, m_tlast);
        end else begin
          e = stream_expect.pop_front();
          if (m_tdata !== e.value) begin
            errors++;
            $display("%0t: byte mismatch: expected %h, actual %h", $time, e.value, m_tdata);
          end
          if (m_tlast !== e.last) begin
            errors++;
            $display("%0t: last mismatch: expected %b, actual %b", $time, e.last, m_tlast);
          end
        end
      end
      if (!rst && s_tvalid && s_tready) begin
        r.cmd = s_tuser;
        r.data = s_tdata[63:0];
        r.count = s_tdata[70:64];
        r.gap = 0;
        r.hold = 1'b0;
        reqs_done++;
        predict_bytes(r);
      end
    end
  end

  // Driver: offers queued requests after their gap, holding each until taken.
  always @(negedge clk) begin
    append_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !req_taken) begin
      s_tvalid <= 1'b1;
    end else if (append_queue.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (append_queue[0].hold && stream_expect.size() != 0) begin
      s_tvalid <= 1'b0;
    end else if (send_wait < append_queue[0].gap) begin
      send_wait++;
      s_tvalid <= 1'b0;
    end else begin
      r = append_queue.pop_front();
      send_wait = 0;
      s_tvalid <= 1'b1;
      s_tuser <= r.cmd;
      s_tdata <= {1'b0, r.count, r.data};
    end
  end

  // Receiver: stalls a random number of cycles after each byte, with calm stretches.
  always @(negedge clk) begin
    if (byte_taken) begin
      rx_seen++;
      if (rx_seen % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      rx_wait = rx_calm ? 0 : $urandom_range(0, 9);
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    logic [63:0] ones;
    logic        cmd;
    logic [63:0] data;
    logic [6:0]  count;
    int          pick;
    bit          calm;
    ones = '1;

    // Directed requests: empty appends, full widths, clamped counts, padding.
    add_req(lsbbp_pkg::CMD_BITS,  ones, 7'd0, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  64'h5, 7'd3, 1, 0);
    add_req(lsbbp_pkg::CMD_BYTES, ones, 7'd0, 0, 0);
    add_req(lsbbp_pkg::CMD_BYTES, ones, 7'd0, 2, 0);
    add_req(lsbbp_pkg::CMD_BITS,  ones, 7'd64, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  ones, 7'd5, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  64'h0123_4567_89AB_CDEF, 7'd64, 3, 0);
    add_req(lsbbp_pkg::CMD_BITS,  64'hFEDC_BA98_7654_3210, 7'd127, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  64'h8000_0000_0000_0001, 7'd65, 0, 0);
    add_req(lsbbp_pkg::CMD_BYTES, 64'hA1B2_C3D4_E5F6_0718, 7'd8, 1, 0);
    add_req(lsbbp_pkg::CMD_BITS,  ones, 7'd1, 0, 0);
    add_req(lsbbp_pkg::CMD_BYTES, 64'h1122_3344_5566_7788, 7'd9, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  64'h2, 7'd2, 0, 0);
    add_req(lsbbp_pkg::CMD_BYTES, ones, 7'd127, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  ones, 7'd7, 4, 0);
    add_req(lsbbp_pkg::CMD_BITS,  ones, 7'd1, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  64'h0, 7'd8, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  64'h1, 7'd1, 0, 0);
    add_req(lsbbp_pkg::CMD_BYTES, 64'hFFFF_FFFF_FFFF_FFA5, 7'd1, 0, 0);
    add_req(lsbbp_pkg::CMD_BYTES, 64'h0, 7'd8, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  ones, 7'd63, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  ones, 7'd1, 0, 0);
    add_req(lsbbp_pkg::CMD_BITS,  ones, 7'd6, 0, 0);
    // Pause until the core has drained before the random part.
    add_req(lsbbp_pkg::CMD_BYTES, 64'h00C3, 7'd2, 0, 1);

    // Random requests, with stretches that offer back to back.
    calm = 1'b0;
    for (int k = 0; k < 400; k++) begin
      if (k % 50 == 0) calm = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 9);
      data = (pick == 0) ? ones : (pick == 1) ? 64'd0 : {$urandom(), $urandom()};
      cmd = ($urandom_range(0, 3) == 0) ? lsbbp_pkg::CMD_BYTES : lsbbp_pkg::CMD_BITS;
      pick = $urandom_range(0, 19);
      if (cmd == lsbbp_pkg::CMD_BITS) begin
        if (pick < 12) count = 7'($urandom_range(0, 16));
        else if (pick < 16) count = 7'($urandom_range(17, 56));
        else if (pick < 19) count = 7'($urandom_range(57, 64));
        else count = 7'($urandom_range(65, 127));
      end else begin
        count = (pick < 18) ? 7'($urandom_range(0, 8)) : 7'($urandom_range(9, 127));
      end
      add_req(cmd, data, count, calm ? 0 : $urandom_range(0, 9), (k == 200));
    end

    repeat (8) @(negedge clk);
    rst = 1'b0;

    while (append_queue.size() != 0 || s_tvalid || stream_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stream_expect.size() != 0) begin
      errors++;
      $display("%0t: %0d expected bytes never arrived", $time, stream_expect.size());
    end

    $display("Covered %0d append requests and %0d stream bytes,", reqs_done, bytes_done);
    $display("including %0d padded partial bytes and %0d clamped counts.",
             pad_bytes, clamped);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
